// ===== src/ftpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ftpp_pkg
// Types and codes shared by the file transfer packet parser modules.
// ----------------------------------------------------------------------------
package ftpp_pkg;

	// size digits kept before further digits are dropped (1 to 9)
	localparam logic [3:0] MAX_SIZE_DIGITS = 4'd9;

	// parse phases
	typedef enum logic [2:0] {
		PH_CTRL     = 3'd0,
		PH_TYPE     = 3'd1,
		PH_SIZE_LEN = 3'd2,
		PH_SIZE_VAL = 3'd3,
		PH_NAME_LEN = 3'd4,
		PH_NAME_VAL = 3'd5,
		PH_SEQ      = 3'd6,
		PH_DATA     = 3'd7
	} phase_t;

	// closing status codes
	typedef enum logic [2:0] {
		ST_DATA         = 3'd0,
		ST_START        = 3'd1,
		ST_END          = 3'd2,
		ST_NOT_CONTROL  = 3'd3,
		ST_UNKNOWN_TYPE = 3'd4,
		ST_OUT_OF_SEQ   = 3'd5
	} status_t;

	// latched error code: no error is code zero
	localparam logic [2:0] ERR_NONE = 3'd0;

	// packet kinds, as given by the control byte
	localparam logic [1:0] PK_NONE  = 2'd0;
	localparam logic [1:0] PK_DATA  = 2'd1;
	localparam logic [1:0] PK_START = 2'd2;
	localparam logic [1:0] PK_END   = 2'd3;

	// tlv field types
	localparam logic [7:0] TLV_SIZE = 8'd0;
	localparam logic [7:0] TLV_NAME = 8'd1;

	// ascii digit bounds
	localparam logic [7:0] ASCII_0 = 8'h30;
	localparam logic [7:0] ASCII_9 = 8'h39;

	// kinds of passed-on byte
	localparam logic [1:0] BK_NONE    = 2'd0;
	localparam logic [1:0] BK_NAME    = 2'd1;
	localparam logic [1:0] BK_CONTENT = 2'd2;

	// data length byte position
	localparam logic [3:0] LEN_HI  = 4'd0;
	localparam logic [3:0] LEN_LO  = 4'd1;
	localparam logic [3:0] LEN_DONE = 4'd2;

	localparam logic [7:0] SEQ_RESET = 8'd255;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  byte_kind;
		logic [7:0]  byte_value;
		logic        packet_done;
		logic [2:0]  status;
		logic [29:0] file_size;
		logic [7:0]  sequence_res;
		logic [15:0] content_length;
	} rsp_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  packet_kind;
		logic [2:0]  error_code;
		logic [15:0] field_remaining;
		logic [3:0]  digit_count;
		logic [29:0] size_acc;
		logic [7:0]  last_seq;
		logic [7:0]  cur_seq;
		logic [15:0] length;
		logic        digits_ended;
	} state_t;

endpackage

// ===== src/ftpp_step.sv =====
// ----------------------------------------------------------------------------
// ftpp_step
// Next-state and result logic for one packet byte.
// ----------------------------------------------------------------------------
module ftpp_step (
	input  ftpp_pkg::state_t cur,
	input  ftpp_pkg::req_t   req,
	output ftpp_pkg::state_t nxt,
	output ftpp_pkg::rsp_t   rsp,
	output logic             has_rsp
);

	logic [7:0]  b;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [2:0]  status;
	logic        is_digit;
	logic [29:0] acc_x10;

	assign b        = req.byte_in;
	assign is_digit = (b >= ftpp_pkg::ASCII_0) && (b <= ftpp_pkg::ASCII_9);
	// times ten as shift and add, plus the digit value
	assign acc_x10  = {cur.size_acc[26:0], 3'b000} + {cur.size_acc[28:0], 1'b0}
		+ {26'd0, b[3:0]};

	always_comb begin
		nxt   = cur;
		kind  = ftpp_pkg::BK_NONE;
		value = 8'd0;
		if (cur.error_code == ftpp_pkg::ERR_NONE) begin
			unique case (cur.phase)
				ftpp_pkg::PH_CTRL: begin
					if (b >= {6'd0, ftpp_pkg::PK_DATA} && b <= {6'd0, ftpp_pkg::PK_END}) begin
						nxt.packet_kind = b[1:0];
						nxt.phase = (b[1:0] == ftpp_pkg::PK_DATA) ?
							ftpp_pkg::PH_SEQ : ftpp_pkg::PH_TYPE;
					end else begin
						nxt.error_code = ftpp_pkg::ST_NOT_CONTROL;
					end
				end
				ftpp_pkg::PH_TYPE: begin
					if (b == ftpp_pkg::TLV_SIZE) begin
						nxt.phase = ftpp_pkg::PH_SIZE_LEN;
					end else if (b == ftpp_pkg::TLV_NAME) begin
						nxt.phase = ftpp_pkg::PH_NAME_LEN;
					end else begin
						nxt.error_code = ftpp_pkg::ST_UNKNOWN_TYPE;
					end
				end
				ftpp_pkg::PH_SIZE_LEN: begin
					nxt.size_acc        = 30'd0;
					nxt.digit_count     = 4'd0;
					nxt.digits_ended    = 1'b0;
					nxt.field_remaining = {8'd0, b};
					nxt.phase = (b == 8'd0) ? ftpp_pkg::PH_TYPE : ftpp_pkg::PH_SIZE_VAL;
				end
				ftpp_pkg::PH_SIZE_VAL: begin
					if (!cur.digits_ended) begin
						if (is_digit) begin
							if (cur.digit_count < ftpp_pkg::MAX_SIZE_DIGITS) begin
								nxt.size_acc    = acc_x10;
								nxt.digit_count = cur.digit_count + 4'd1;
							end
						end else begin
							nxt.digits_ended = 1'b1;
						end
					end
					nxt.field_remaining = cur.field_remaining - 16'd1;
					if (cur.field_remaining == 16'd1) begin
						nxt.phase = ftpp_pkg::PH_TYPE;
					end
				end
				ftpp_pkg::PH_NAME_LEN: begin
					nxt.field_remaining = {8'd0, b};
					nxt.phase = (b == 8'd0) ? ftpp_pkg::PH_TYPE : ftpp_pkg::PH_NAME_VAL;
				end
				ftpp_pkg::PH_NAME_VAL: begin
					kind  = ftpp_pkg::BK_NAME;
					value = b;
					nxt.field_remaining = cur.field_remaining - 16'd1;
					if (cur.field_remaining == 16'd1) begin
						nxt.phase = ftpp_pkg::PH_TYPE;
					end
				end
				ftpp_pkg::PH_SEQ: begin
					nxt.cur_seq = b;
					if (cur.last_seq + 8'd1 != b) begin
						nxt.error_code = ftpp_pkg::ST_OUT_OF_SEQ;
					end else begin
						nxt.last_seq    = b;
						nxt.digit_count = ftpp_pkg::LEN_HI;
						nxt.phase       = ftpp_pkg::PH_DATA;
					end
				end
				ftpp_pkg::PH_DATA: begin
					if (cur.digit_count == ftpp_pkg::LEN_HI) begin
						nxt.length      = {b, 8'd0};
						nxt.digit_count = ftpp_pkg::LEN_LO;
					end else if (cur.digit_count == ftpp_pkg::LEN_LO) begin
						nxt.length          = {cur.length[15:8], b};
						nxt.field_remaining = {cur.length[15:8], b};
						nxt.digit_count     = ftpp_pkg::LEN_DONE;
					end else if (cur.field_remaining != 16'd0) begin
						kind  = ftpp_pkg::BK_CONTENT;
						value = b;
						nxt.field_remaining = cur.field_remaining - 16'd1;
					end
				end
				default: begin
				end
			endcase
		end

		status = ftpp_pkg::ST_DATA;
		if (req.last_byte) begin
			priority if (nxt.error_code != ftpp_pkg::ERR_NONE) begin
				status = nxt.error_code;
			end else if (nxt.packet_kind == ftpp_pkg::PK_START) begin
				status = ftpp_pkg::ST_START;
			end else if (nxt.packet_kind == ftpp_pkg::PK_END) begin
				status = ftpp_pkg::ST_END;
			end else begin
				status = ftpp_pkg::ST_DATA;
			end
		end

		rsp.byte_kind      = kind;
		rsp.byte_value     = value;
		rsp.packet_done    = req.last_byte;
		rsp.status         = status;
		rsp.file_size      = nxt.size_acc;
		rsp.sequence_res   = nxt.cur_seq;
		rsp.content_length = nxt.length;
		has_rsp = req.last_byte || (kind != ftpp_pkg::BK_NONE);

		// packet closes: everything but the sequence history returns to reset
		if (req.last_byte) begin
			nxt.phase           = ftpp_pkg::PH_CTRL;
			nxt.packet_kind     = ftpp_pkg::PK_NONE;
			nxt.error_code      = ftpp_pkg::ERR_NONE;
			nxt.field_remaining = 16'd0;
			nxt.digit_count     = 4'd0;
			nxt.size_acc        = 30'd0;
			nxt.cur_seq         = 8'd0;
			nxt.length          = 16'd0;
			nxt.digits_ended    = 1'b0;
		end
	end

endmodule

// ===== src/file_transfer_packet_parser.sv =====
// ----------------------------------------------------------------------------
// file_transfer_packet_parser
// Byte-serial parser for data, start and end packets of a file transfer link.
// ----------------------------------------------------------------------------
// One packet byte enters per request on the req channel, last_byte closing the
// packet. The block takes one byte every cycle unless a held result waits on
// rsp_stall: the per-byte work is a single state update between the input
// register and the result register, so the sustained rate is one byte per
// clock while rsp is not stalled. A result is made for every file name byte,
// every content byte and the last byte of each packet (which carries
// packet_done and the status); other bytes make none. Name bytes come out with
// byte_kind 1, content bytes with byte_kind 2. An error (bad control byte,
// unknown field type, sequence number out of order) holds until the packet
// ends and is given as the closing status. The expected sequence number
// survives from packet to packet and starts so that the first data packet must
// carry 0.
module file_transfer_packet_parser (
	input  logic           clk,
	input  logic           arst_n,
	// request channel
	input  logic           req_valid,
	output logic           req_stall,
	input  ftpp_pkg::req_t req_data,
	// result channel
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ftpp_pkg::rsp_t rsp_data
);

	// input register
	logic             vld_s1;
	ftpp_pkg::req_t   req_s1;

	// parser state
	ftpp_pkg::state_t st_q;
	ftpp_pkg::state_t st_nxt;

	// result register
	logic             rsp_vld_q;
	ftpp_pkg::rsp_t   rsp_q;

	ftpp_pkg::rsp_t   rsp_nxt;
	logic             has_rsp;
	logic             out_free;
	logic             take_s1;

	ftpp_step u_step (
		.cur     (st_q),
		.req     (req_s1),
		.nxt     (st_nxt),
		.rsp     (rsp_nxt),
		.has_rsp (has_rsp)
	);

	// result register is free when empty or being taken this cycle
	assign out_free = !rsp_vld_q || !rsp_stall;
	// a byte with no result never waits on the output side
	assign take_s1  = vld_s1 && (!has_rsp || out_free);
	// stall the request side only while the held byte cannot move on
	assign req_stall = vld_s1 && !take_s1;

	// input register: refills whenever its byte moves on or it is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!req_stall) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
	end

	// parser state advances once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= ftpp_pkg::PH_CTRL;
			st_q.packet_kind     <= ftpp_pkg::PK_NONE;
			st_q.error_code      <= ftpp_pkg::ERR_NONE;
			st_q.field_remaining <= 16'd0;
			st_q.digit_count     <= 4'd0;
			st_q.size_acc        <= 30'd0;
			st_q.last_seq        <= ftpp_pkg::SEQ_RESET;
			st_q.cur_seq         <= 8'd0;
			st_q.length          <= 16'd0;
			st_q.digits_ended    <= 1'b0;
		end else if (take_s1) begin
			st_q <= st_nxt;
		end
	end

	// result register with hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (take_s1 && has_rsp) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && has_rsp) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== dv/ftpp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftpp_checker
// Follows the packet parser request by request and checks its results in order.
// ----------------------------------------------------------------------------
module ftpp_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  ftpp_pkg::req_t req_data,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  ftpp_pkg::rsp_t rsp_data,
	output int             results_pending,
	output int             mismatch_count
);

	// parser state as the bytes walk through it
	ftpp_pkg::phase_t phase;
	logic [1:0]  pkt_kind;
	logic [2:0]  err_code;
	logic [15:0] remaining;
	logic [3:0]  digit_cnt;
	logic [29:0] size_acc;
	logic [7:0]  last_seq;
	logic [7:0]  cur_seq;
	logic [15:0] data_len;
	logic        digits_done;

	ftpp_pkg::rsp_t parser_results[$];
	ftpp_pkg::rsp_t oldest;

	function void clear_packet_state();
		phase       = ftpp_pkg::PH_CTRL;
		pkt_kind    = ftpp_pkg::PK_NONE;
		err_code    = ftpp_pkg::ERR_NONE;
		remaining   = '0;
		digit_cnt   = '0;
		size_acc    = '0;
		cur_seq     = '0;
		data_len    = '0;
		digits_done = 1'b0;
	endfunction

	task parse_byte(input ftpp_pkg::req_t r);
		ftpp_pkg::rsp_t res;
		logic [1:0] kind;
		logic [7:0] value;
		logic [7:0] b;
		b     = r.byte_in;
		kind  = ftpp_pkg::BK_NONE;
		value = '0;
		if (err_code == ftpp_pkg::ERR_NONE) begin
			case (phase)
				ftpp_pkg::PH_CTRL: begin
					if (b >= {6'd0, ftpp_pkg::PK_DATA} && b <= {6'd0, ftpp_pkg::PK_END}) begin
						pkt_kind = b[1:0];
						phase    = (b[1:0] == ftpp_pkg::PK_DATA) ?
							ftpp_pkg::PH_SEQ : ftpp_pkg::PH_TYPE;
					end else begin
						err_code = ftpp_pkg::ST_NOT_CONTROL;
					end
				end
				ftpp_pkg::PH_TYPE: begin
					if (b == ftpp_pkg::TLV_SIZE)
						phase = ftpp_pkg::PH_SIZE_LEN;
					else if (b == ftpp_pkg::TLV_NAME)
						phase = ftpp_pkg::PH_NAME_LEN;
					else
						err_code = ftpp_pkg::ST_UNKNOWN_TYPE;
				end
				ftpp_pkg::PH_SIZE_LEN: begin
					size_acc    = '0;
					digit_cnt   = '0;
					digits_done = 1'b0;
					remaining   = {8'd0, b};
					phase       = (b == 8'd0) ? ftpp_pkg::PH_TYPE : ftpp_pkg::PH_SIZE_VAL;
				end
				ftpp_pkg::PH_SIZE_VAL: begin
					if (!digits_done) begin
						if (b >= ftpp_pkg::ASCII_0 && b <= ftpp_pkg::ASCII_9) begin
							if (digit_cnt < ftpp_pkg::MAX_SIZE_DIGITS) begin
								size_acc  = size_acc * 30'd10
									+ {22'd0, b - ftpp_pkg::ASCII_0};
								digit_cnt = digit_cnt + 4'd1;
							end
						end else begin
							digits_done = 1'b1;
						end
					end
					remaining = remaining - 16'd1;
					if (remaining == 16'd0)
						phase = ftpp_pkg::PH_TYPE;
				end
				ftpp_pkg::PH_NAME_LEN: begin
					remaining = {8'd0, b};
					phase     = (b == 8'd0) ? ftpp_pkg::PH_TYPE : ftpp_pkg::PH_NAME_VAL;
				end
				ftpp_pkg::PH_NAME_VAL: begin
					kind      = ftpp_pkg::BK_NAME;
					value     = b;
					remaining = remaining - 16'd1;
					if (remaining == 16'd0)
						phase = ftpp_pkg::PH_TYPE;
				end
				ftpp_pkg::PH_SEQ: begin
					cur_seq = b;
					if (last_seq + 8'd1 != b) begin
						err_code = ftpp_pkg::ST_OUT_OF_SEQ;
					end else begin
						last_seq  = b;
						digit_cnt = ftpp_pkg::LEN_HI;
						phase     = ftpp_pkg::PH_DATA;
					end
				end
				default: begin
					if (digit_cnt == ftpp_pkg::LEN_HI) begin
						data_len  = {b, 8'd0};
						digit_cnt = ftpp_pkg::LEN_LO;
					end else if (digit_cnt == ftpp_pkg::LEN_LO) begin
						data_len  = data_len | {8'd0, b};
						remaining = data_len;
						digit_cnt = ftpp_pkg::LEN_DONE;
					end else if (remaining != 16'd0) begin
						kind      = ftpp_pkg::BK_CONTENT;
						value     = b;
						remaining = remaining - 16'd1;
					end
				end
			endcase
		end

		if (r.last_byte || kind != ftpp_pkg::BK_NONE) begin
			res.byte_kind   = kind;
			res.byte_value  = value;
			res.packet_done = r.last_byte;
			// status reads zero while the packet is open
			res.status      = ftpp_pkg::ST_DATA;
			if (r.last_byte) begin
				if (err_code != ftpp_pkg::ERR_NONE)
					res.status = err_code;
				else if (pkt_kind == ftpp_pkg::PK_START)
					res.status = ftpp_pkg::ST_START;
				else if (pkt_kind == ftpp_pkg::PK_END)
					res.status = ftpp_pkg::ST_END;
			end
			res.file_size      = size_acc;
			res.sequence_res   = cur_seq;
			res.content_length = data_len;
			parser_results.push_back(res);
		end

		if (r.last_byte)
			clear_packet_state();
	endtask

	task compare_field(input string name, input logic [29:0] want, input logic [29:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet_state();
			last_seq = ftpp_pkg::SEQ_RESET;
			parser_results.delete();
			mismatch_count = 0;
			results_pending <= 0;
		end else begin
			if (req_valid && !req_stall)
				parse_byte(req_data);
			if (rsp_valid && !rsp_stall) begin
				if (parser_results.size() == 0) begin
					$error("result with none predicted: byte_kind %0d, packet_done %0d",
						rsp_data.byte_kind, rsp_data.packet_done);
					mismatch_count++;
				end else begin
					oldest = parser_results.pop_front();
					compare_field("byte_kind", oldest.byte_kind, rsp_data.byte_kind);
					compare_field("byte_value", oldest.byte_value, rsp_data.byte_value);
					compare_field("packet_done", oldest.packet_done, rsp_data.packet_done);
					compare_field("status", oldest.status, rsp_data.status);
					compare_field("file_size", oldest.file_size, rsp_data.file_size);
					compare_field("sequence_res", oldest.sequence_res, rsp_data.sequence_res);
					compare_field("content_length", oldest.content_length,
						rsp_data.content_length);
				end
			end
			results_pending <= parser_results.size();
		end
	end

endmodule

// ===== dv/tb_file_transfer_packet_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_file_transfer_packet_parser
// Feeds whole packets byte by byte into the parser and reports the verdict.
// A short directed set hits bad control bytes, unknown field types, bad
// sequence numbers, size digits, truncation and trailing bytes; then random
// packets, mostly well formed, run under three idle patterns on both sides.
// Result checking lives in ftpp_checker.
// ----------------------------------------------------------------------------
module tb_file_transfer_packet_parser;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	ftpp_pkg::req_t req_data;
	logic           rsp_valid;
	logic           rsp_stall;
	ftpp_pkg::rsp_t rsp_data;

	int         results_pending;
	int         mismatch_count;

	// idle chance per cycle, in percent, for the sending and receiving side
	int         send_idle_pct;
	int         recv_idle_pct;

	// bytes of the packet being built, last one gets last_byte
	logic [7:0] pkt_bytes[$];
	// sequence number the parser will take next
	logic [7:0] next_seq;
	int         bytes_sent;

	file_transfer_packet_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	ftpp_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_data       (req_data),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp_data       (rsp_data),
		.results_pending(results_pending),
		.mismatch_count (mismatch_count)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver stalls at random, one draw per cycle
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// hard stop in case the parser hangs
	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// one request: optional idle cycles, then hold until accepted
	task send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= {b, last};
		do @(posedge clk); while (req_stall);
	endtask

	task send_packet();
		int i;
		// a data packet whose sequence byte matches moves the parser on
		if (pkt_bytes.size() >= 2 && pkt_bytes[0] == {6'd0, ftpp_pkg::PK_DATA} &&
				pkt_bytes[1] == next_seq)
			next_seq = next_seq + 8'd1;
		for (i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		bytes_sent += pkt_bytes.size();
		pkt_bytes.delete();
	endtask

	// stop sending until every predicted result has come out
	task drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	task build_random_packet();
		int         sel;
		int         nf;
		int         f;
		int         flen;
		int         i;
		int         r;
		int         keep;
		int         min_keep;
		logic [7:0] b;
		logic [15:0] len16;
		sel      = $urandom_range(99);
		min_keep = 1;
		if (sel < 40) begin
			// data packet, sequence mostly right, content short
			pkt_bytes.push_back({6'd0, ftpp_pkg::PK_DATA});
			b = 8'($urandom_range(255));
			if ($urandom_range(99) < 85)
				b = next_seq;
			pkt_bytes.push_back(b);
			flen  = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(12);
			len16 = flen[15:0];
			pkt_bytes.push_back(len16[15:8]);
			pkt_bytes.push_back(len16[7:0]);
			// a huge declared length ends early
			if (flen > 12)
				flen = $urandom_range(4);
			for (i = 0; i < flen; i++) begin
				b = 8'($urandom_range(255));
				pkt_bytes.push_back(b);
			end
			// bytes past the declared content are dropped by the parser
			if ($urandom_range(4) == 0) begin
				for (i = $urandom_range(1, 3); i > 0; i--) begin
					b = 8'($urandom_range(255));
					pkt_bytes.push_back(b);
				end
			end
			min_keep = 2;
		end else if (sel < 80) begin
			// start or end packet made of tlv fields
			pkt_bytes.push_back((sel < 60) ? {6'd0, ftpp_pkg::PK_START} :
				{6'd0, ftpp_pkg::PK_END});
			nf = $urandom_range(1, 4);
			for (f = 0; f < nf; f++) begin
				r = $urandom_range(99);
				if (r < 45) begin
					// size field, up to twelve chars so the digit cap gets hit
					pkt_bytes.push_back(ftpp_pkg::TLV_SIZE);
					flen = $urandom_range(12);
					pkt_bytes.push_back(flen[7:0]);
					for (i = 0; i < flen; i++) begin
						b = ftpp_pkg::ASCII_0 + 8'($urandom_range(9));
						if ($urandom_range(9) == 0)
							b = 8'($urandom_range(255));
						pkt_bytes.push_back(b);
					end
				end else if (r < 92) begin
					pkt_bytes.push_back(ftpp_pkg::TLV_NAME);
					flen = $urandom_range(8);
					pkt_bytes.push_back(flen[7:0]);
					for (i = 0; i < flen; i++) begin
						b = 8'($urandom_range(255));
						pkt_bytes.push_back(b);
					end
				end else begin
					// field type the parser does not know
					b = 8'($urandom_range(2, 255));
					pkt_bytes.push_back(b);
				end
			end
		end else begin
			// noise: any bytes at all
			for (i = $urandom_range(1, 6); i > 0; i--) begin
				b = 8'($urandom_range(255));
				pkt_bytes.push_back(b);
			end
		end
		// now and then cut the packet short
		if ($urandom_range(11) == 0) begin
			keep = $urandom_range(pkt_bytes.size(), min_keep);
			while (pkt_bytes.size() > keep)
				b = pkt_bytes.pop_back();
		end
	endtask

	initial begin
		int phase_no;
		int target;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_data      = '0;
		send_idle_pct = 37;
		recv_idle_pct = 86;
		next_seq      = ftpp_pkg::SEQ_RESET + 8'd1;
		bytes_sent    = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// data packet with the first sequence number, one content byte of
		// all ones and a trailing byte that must be ignored
		pkt_bytes.push_back({6'd0, ftpp_pkg::PK_DATA});
		pkt_bytes.push_back(next_seq);
		pkt_bytes.push_back(8'h00);
		pkt_bytes.push_back(8'h01);
		pkt_bytes.push_back(8'hFF);
		pkt_bytes.push_back(8'h00);
		send_packet();

		// zero is no control byte: error latches, the rest is ignored
		pkt_bytes.push_back(8'h00);
		pkt_bytes.push_back(8'hFF);
		send_packet();

		// start packet: size digits broken by a letter, one name byte,
		// then an unknown field type on the last byte
		pkt_bytes.push_back({6'd0, ftpp_pkg::PK_START});
		pkt_bytes.push_back(ftpp_pkg::TLV_SIZE);
		pkt_bytes.push_back(8'd3);
		pkt_bytes.push_back(ftpp_pkg::ASCII_9);
		pkt_bytes.push_back(8'h78);
		pkt_bytes.push_back(ftpp_pkg::ASCII_0 + 8'd5);
		pkt_bytes.push_back(ftpp_pkg::TLV_NAME);
		pkt_bytes.push_back(8'd1);
		pkt_bytes.push_back(8'h41);
		pkt_bytes.push_back(8'd7);
		send_packet();

		// sequence number out of order
		pkt_bytes.push_back({6'd0, ftpp_pkg::PK_DATA});
		pkt_bytes.push_back(next_seq + 8'd4);
		send_packet();

		// end packet: empty size and name fields, cut off inside a third field
		pkt_bytes.push_back({6'd0, ftpp_pkg::PK_END});
		pkt_bytes.push_back(ftpp_pkg::TLV_SIZE);
		pkt_bytes.push_back(8'd0);
		pkt_bytes.push_back(ftpp_pkg::TLV_NAME);
		pkt_bytes.push_back(8'd0);
		pkt_bytes.push_back(ftpp_pkg::TLV_SIZE);
		send_packet();
		drain_results();

		// random packets: slow receiver, then slow sender, then full speed
		for (phase_no = 0; phase_no < 3; phase_no++) begin
			if (phase_no == 1) begin
				send_idle_pct = 86;
				recv_idle_pct = 37;
			end else if (phase_no == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			target = bytes_sent + 475;
			while (bytes_sent < target) begin
				build_random_packet();
				send_packet();
				if ($urandom_range(49) == 0)
					drain_results();
			end
			drain_results();
		end

		// let any stray result show up
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ftpp_pkg.sv
src/ftpp_step.sv
src/file_transfer_packet_parser.sv
dv/ftpp_checker.sv
dv/tb_file_transfer_packet_parser.sv
